// ===== hdl/lspq_pkg.sv =====
// ----------------------------------------------------------------------------
// lspq_pkg
// Types, constants and the entry ordering shared by the priority queue files.
// ----------------------------------------------------------------------------
package lspq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] t_word;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_count;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_word value;
        t_word prio;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        logic   re;
        t_addr  raddr;
    } t_mem_cmd;

    typedef struct packed {
        t_addr  b1_idx;
        t_entry b1;
        logic   b2_vld;
        t_entry b2;
    } t_best;

    // True when entry a is served before an earlier entry b.
    function automatic logic beats(t_entry a, t_entry b);
        return (a.prio > b.prio) ||
               ((a.prio == b.prio) && (a.value > b.value));
    endfunction

endpackage

// ===== hdl/lspq_if.sv =====
// ----------------------------------------------------------------------------
// lspq_req_if / lspq_rsp_if
// Valid/ready channels for request and response words of the queue.
// ----------------------------------------------------------------------------
interface lspq_req_if import lspq_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  req_type;
    t_word item_value;
    t_word item_priority;

    modport source (output valid, req_type, item_value, item_priority, input ready);
    modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface lspq_rsp_if import lspq_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    t_word      removed_value;
    t_word      removed_priority;
    logic       top_valid;
    t_word      top_value;
    t_word      top_priority;
    logic [6:0] entry_count;
    logic       is_full;

    modport source (output valid, status, removed_value, removed_priority, top_valid,
                    top_value, top_priority, entry_count, is_full, input ready);
    modport sink   (input valid, status, removed_value, removed_priority, top_valid,
                    top_value, top_priority, entry_count, is_full, output ready);
endinterface

// ===== hdl/linear_scan_priority_queue.sv =====
// ----------------------------------------------------------------------------
// linear_scan_priority_queue
// Unsorted-array priority queue with a scanning remove and a shifting close.
// ----------------------------------------------------------------------------
// Requests arrive as words on i_req (insert or remove), and each request
// gives exactly one response word on o_rsp with the status, the removed
// entry, the best entry left, the count and the full flag.
// Entries are kept in insertion order in a single-port-write, registered-read
// store. The best entry is tracked in a register, so an insert needs no scan:
// it goes straight to the finish state, which loads its response.
// A remove scans all N stored entries through one compare unit, passes a
// setup state, then shifts the entries after the removed one down at one
// per cycle (none move when it is the last entry); the scan and the shift
// both go over the store's single read port.
// The scan also finds the runner-up, which becomes the new best entry.
// i_req.ready is high only while no request is at work.
// A finished response waits in the output register; if o_rsp is stalled the
// next request is still accepted and worked on, and its completion waits
// until the held word is taken. Reset empties the queue and drops any
// pending response; the store itself is not cleared.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue import lspq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lspq_req_if.sink    i_req,
    lspq_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SETUP,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state   r_state;
    t_count   r_count;
    t_count   r_rd_idx;
    t_addr    r_cmp_idx;
    logic     r_cmp_vld;
    t_entry   r_top;
    t_status  r_res_status;
    t_entry   r_res_removed;

    logic     r_out_valid;
    t_status  r_out_status;
    t_entry   r_out_removed;
    logic     r_out_top_valid;
    t_entry   r_out_top;
    t_count   r_out_count;
    logic     r_out_full;

    t_mem_cmd mem_cmd;
    t_entry   rd_data;
    t_best    best;
    t_entry   new_entry;
    logic     accept;
    logic     is_full;
    logic     read_more;
    logic     scan_last;

    assign new_entry = '{value: i_req.item_value, prio: i_req.item_priority};
    assign accept    = i_req.valid && i_req.ready;
    assign is_full   = (r_count == t_count'(CAPACITY));
    assign read_more = (r_rd_idx < r_count);
    assign scan_last = r_cmp_vld && (t_count'(r_cmp_idx) == r_count - t_count'(1));

    always_comb begin
        mem_cmd       = '0;
        mem_cmd.wdata = new_entry;
        mem_cmd.waddr = t_addr'(r_count);
        mem_cmd.raddr = t_addr'(r_rd_idx);
        unique case (r_state)
            S_IDLE: begin
                mem_cmd.we = accept && (i_req.req_type == REQ_INSERT) && !is_full;
            end
            S_SCAN: begin
                mem_cmd.re = read_more;
            end
            S_SHIFT: begin
                mem_cmd.re    = read_more;
                mem_cmd.we    = r_cmp_vld;
                mem_cmd.waddr = r_cmp_idx - t_addr'(1);
                mem_cmd.wdata = rd_data;
            end
            default: begin
            end
        endcase
    end

    lspq_mem u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    lspq_best u_best (
        .i_clk   (i_clk),
        .i_en    ((r_state == S_SCAN) && r_cmp_vld),
        .i_idx   (r_cmp_idx),
        .i_entry (rd_data),
        .o_best  (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_removed <= '0;
                        if (i_req.req_type == REQ_INSERT) begin
                            r_state <= S_FINISH;
                            if (is_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_DONE;
                                r_count      <= r_count + t_count'(1);
                                if (r_count == '0 || beats(new_entry, r_top)) begin
                                    r_top <= new_entry;
                                end
                            end
                        end else if (r_count == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_FINISH;
                        end else begin
                            r_rd_idx  <= '0;
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= read_more;
                    r_cmp_idx <= t_addr'(r_rd_idx);
                    if (read_more) begin
                        r_rd_idx <= r_rd_idx + t_count'(1);
                    end
                    if (scan_last) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_rd_idx  <= t_count'(best.b1_idx) + t_count'(1);
                    r_cmp_vld <= 1'b0;
                    r_state   <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_cmp_vld <= read_more;
                    r_cmp_idx <= t_addr'(r_rd_idx);
                    if (read_more) begin
                        r_rd_idx <= r_rd_idx + t_count'(1);
                    end else if (!r_cmp_vld) begin
                        // Every later entry has moved down one place.
                        r_count       <= r_count - t_count'(1);
                        r_res_status  <= ST_DONE;
                        r_res_removed <= best.b1;
                        r_top         <= best.b2;
                        r_state       <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid     <= 1'b1;
                        r_out_status    <= r_res_status;
                        r_out_removed   <= r_res_removed;
                        r_out_top_valid <= (r_count != '0);
                        r_out_top       <= (r_count != '0) ? r_top : '0;
                        r_out_count     <= r_count;
                        r_out_full      <= is_full;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.removed_value    = r_out_removed.value;
    assign o_rsp.removed_priority = r_out_removed.prio;
    assign o_rsp.top_valid        = r_out_top_valid;
    assign o_rsp.top_value        = r_out_top.value;
    assign o_rsp.top_priority     = r_out_top.prio;
    assign o_rsp.entry_count      = 7'(r_out_count);
    assign o_rsp.is_full          = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.req_type == REQ_INSERT) && !is_full
        |=> r_count == $past(r_count) + t_count'(1))
        else $error("accepted insert did not grow the count");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) && mem_cmd.we |-> t_count'(mem_cmd.waddr) < r_count)
        else $error("shift writes beyond the stored entries");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_FULL) |-> r_out_full)
        else $error("dropped insert reported without full flag");

endmodule

// ===== hdl/lspq_mem.sv =====
// ----------------------------------------------------------------------------
// lspq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lspq_mem import lspq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_cmd i_cmd,
    output t_entry   o_rd_data
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rd_data <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lspq_best.sv =====
// ----------------------------------------------------------------------------
// lspq_best
// Shared compare unit that keeps the best and second-best entry of a scan.
// ----------------------------------------------------------------------------
module lspq_best import lspq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_addr  i_idx,
    input  t_entry i_entry,
    output t_best  o_best
);

    t_best r_best;

    // Entries arrive in index order, so a strict win against the held entries
    // also keeps the earliest entry on a full tie.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_idx == '0) begin
                r_best.b1_idx <= i_idx;
                r_best.b1     <= i_entry;
                r_best.b2_vld <= 1'b0;
            end else if (beats(i_entry, r_best.b1)) begin
                r_best.b1_idx <= i_idx;
                r_best.b1     <= i_entry;
                r_best.b2     <= r_best.b1;
                r_best.b2_vld <= 1'b1;
            end else if (!r_best.b2_vld || beats(i_entry, r_best.b2)) begin
                r_best.b2     <= i_entry;
                r_best.b2_vld <= 1'b1;
            end
        end
    end

    assign o_best = r_best;

endmodule

// ===== test/lspq_reply_check.sv =====
// ----------------------------------------------------------------------------
// lspq_reply_check
// Watches the request and response channels of the priority queue, keeps its
// own copy of the queue contents, works out the response word due for every
// accepted request and compares it field by field with the words that come
// out, oldest first.
// ----------------------------------------------------------------------------
module lspq_reply_check import lspq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lspq_req_if  req,
    lspq_rsp_if  rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_inserts,
    output int   o_removes,
    output int   o_full_drops,
    output int   o_empty_drops,
    output int   o_peak
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status    status;
        t_word      rem_val;
        t_word      rem_pri;
        logic       top_valid;
        t_word      top_val;
        t_word      top_pri;
        logic [6:0] count;
        logic       full;
    } t_queue_reply;

    t_word        slot_val [CAPACITY];
    t_word        slot_pri [CAPACITY];
    int           held;
    t_queue_reply reply_q [$];
    int           fail_count;
    int           n_inserts, n_removes, n_full, n_empty, peak;

    // Earliest slot with the largest priority, larger value breaking ties.
    function automatic int best_slot();
        int b;
        int i;
        b = 0;
        for (i = 1; i < held; i++) begin
            if (slot_pri[i] > slot_pri[b] ||
                (slot_pri[i] == slot_pri[b] && slot_val[i] > slot_val[b])) begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic t_queue_reply apply_request(logic kind, t_word v, t_word p);
        t_queue_reply r;
        int b;
        int i;
        r.status  = ST_DONE;
        r.rem_val = '0;
        r.rem_pri = '0;
        if (kind == REQ_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                slot_val[held] = v;
                slot_pri[held] = p;
                held++;
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            b = best_slot();
            r.rem_val = slot_val[b];
            r.rem_pri = slot_pri[b];
            for (i = b; i + 1 < held; i++) begin
                slot_val[i] = slot_val[i + 1];
                slot_pri[i] = slot_pri[i + 1];
            end
            held--;
        end
        r.top_valid = (held > 0);
        r.top_val   = '0;
        r.top_pri   = '0;
        if (held > 0) begin
            b = best_slot();
            r.top_val = slot_val[b];
            r.top_pri = slot_pri[b];
        end
        r.count = held[6:0];
        r.full  = (held == CAPACITY);
        return r;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", fname, want, got);
            fail_count++;
        end
    endtask

    initial begin
        held       = 0;
        fail_count = 0;
        n_inserts  = 0;
        n_removes  = 0;
        n_full     = 0;
        n_empty    = 0;
        peak       = 0;
    end

    always @(posedge i_clk) begin
        t_queue_reply want;
        if (!i_rst_n) begin
            held = 0;
            reply_q.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (reply_q.size() == 0) begin
                    $error("response word with no request waiting for it");
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("removed_value", want.rem_val, rsp.removed_value);
                    check_field("removed_priority", want.rem_pri, rsp.removed_priority);
                    check_field("top_valid", want.top_valid, rsp.top_valid);
                    check_field("top_value", want.top_val, rsp.top_value);
                    check_field("top_priority", want.top_pri, rsp.top_priority);
                    check_field("entry_count", want.count, rsp.entry_count);
                    check_field("is_full", want.full, rsp.is_full);
                end
            end
            if (req.valid && req.ready) begin
                want = apply_request(req.req_type, req.item_value, req.item_priority);
                reply_q.push_back(want);
                if (req.req_type == REQ_INSERT) n_inserts++;
                else n_removes++;
                if (want.status == ST_FULL) n_full++;
                if (want.status == ST_EMPTY) n_empty++;
                if (held > peak) peak = held;
            end
        end
        // Registered so that the stimulus side reads them without a race.
        o_fail_count  <= fail_count;
        o_pending     <= reply_q.size();
        o_inserts     <= n_inserts;
        o_removes     <= n_removes;
        o_full_drops  <= n_full;
        o_empty_drops <= n_empty;
        o_peak        <= peak;
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the linear-scan priority queue.
// A short directed sequence covers the empty, tie and extreme-priority cases,
// then random fill, drain and mixed phases push the queue to full and back to
// empty repeatedly, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lspq_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_WAIT   = 2 * CAPACITY + 16;
    localparam int LIMIT        = 1_000_000;

    localparam t_word W_MIN = 32'sh8000_0000;
    localparam t_word W_MAX = 32'sh7fff_ffff;

    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } t_phase_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lspq_req_if req ();
    lspq_rsp_if rsp ();

    int fail_count, pending, n_inserts, n_removes, n_full, n_empty, peak;

    linear_scan_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    lspq_reply_check queue_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req           (req),
        .rsp           (rsp),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_inserts     (n_inserts),
        .o_removes     (n_removes),
        .o_full_drops  (n_full),
        .o_empty_drops (n_empty),
        .o_peak        (peak)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Response side: each window of the 8-bit phase counter either takes every
    // word or stalls on a random 32-bit pattern.
    logic [7:0]  stall_phase = '0;
    logic        stall_on    = 1'b0;
    logic [31:0] stall_bits  = '1;
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_on   <= ($urandom_range(0, 3) != 0);
            stall_bits <= $urandom;
        end
        stall_phase <= stall_phase + 8'd1;
        rsp.ready   <= stall_on ? stall_bits[stall_phase[4:0]] : 1'b1;
    end

    int depth_guess = 0;
    int burst_left  = 0;

    // Mix of extremes, small numbers that make ties likely, and full range.
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return W_MIN;
            1:       return W_MAX;
            2, 3:    return t_word'($urandom_range(0, 6)) - 32'sd3;
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic issue_request(logic kind, t_word v, t_word p);
        int gap;
        req.valid         <= 1'b1;
        req.req_type      <= kind;
        req.item_value    <= v;
        req.item_priority <= p;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        if (kind == REQ_INSERT) begin
            if (depth_guess < CAPACITY) depth_guess++;
        end else if (depth_guess > 0) begin
            depth_guess--;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            // Long gaps now and then so that idle time lands inside a remove.
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2 * CAPACITY + 8)
                                              : $urandom_range(0, 8);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        t_phase_mode mode;
        logic        kind;
        int          n;

        i_rst_n           = 1'b0;
        req.valid         = 1'b0;
        req.req_type      = REQ_INSERT;
        req.item_value    = '0;
        req.item_priority = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Remove from an empty queue.
        issue_request(REQ_REMOVE, W_MAX, W_MAX);
        // Every priority at the minimum: the first entry with the largest value wins.
        issue_request(REQ_INSERT, W_MAX, W_MIN);
        issue_request(REQ_INSERT, W_MIN, W_MIN);
        issue_request(REQ_INSERT, W_MAX, W_MIN);
        issue_request(REQ_REMOVE, '0, '0);
        issue_request(REQ_REMOVE, '0, '0);
        issue_request(REQ_REMOVE, '0, '0);
        // Extremes of both fields and alternating bit patterns.
        issue_request(REQ_INSERT, W_MIN, W_MAX);
        issue_request(REQ_INSERT, W_MAX, W_MAX);
        issue_request(REQ_INSERT, -32'sd1, '0);
        issue_request(REQ_INSERT, '0, -32'sd1);
        issue_request(REQ_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555);
        issue_request(REQ_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA);
        repeat (7) issue_request(REQ_REMOVE, 32'shFFFF_FFFF, 32'shFFFF_FFFF);

        mode = MODE_FILL;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            case (mode)
                MODE_FILL:  kind = ($urandom_range(0, 9) == 0) ? REQ_REMOVE : REQ_INSERT;
                MODE_DRAIN: kind = ($urandom_range(0, 9) == 0) ? REQ_INSERT : REQ_REMOVE;
                default:    kind = ($urandom_range(0, 1) == 0) ? REQ_REMOVE : REQ_INSERT;
            endcase
            issue_request(kind, pick_word(), pick_word());
            // A few inserts bounce off a full queue, a few removes off an empty one.
            if (mode == MODE_FILL && depth_guess == CAPACITY && $urandom_range(0, 3) == 0) begin
                mode = MODE_DRAIN;
            end else if (mode == MODE_DRAIN && depth_guess == 0 &&
                         $urandom_range(0, 2) == 0) begin
                mode = ($urandom_range(0, 1) == 0) ? MODE_FILL : MODE_MIXED;
            end else if (mode == MODE_MIXED && $urandom_range(0, 29) == 0) begin
                mode = MODE_FILL;
            end
        end
        req.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d inserts (%0d refused on a full queue)", n_inserts, n_full);
        $display("and %0d removes (%0d on an empty one).", n_removes, n_empty);
        $display("Queue depth peaked at %0d of %0d entries.", peak, CAPACITY);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lspq_pkg.sv
hdl/lspq_if.sv
hdl/lspq_mem.sv
hdl/lspq_best.sv
hdl/linear_scan_priority_queue.sv
test/lspq_reply_check.sv
test/testbench.sv
